FILE: rtl/htf_pkg.sv
// htf_pkg: shared constants, action codes and tag name matching for the
// html to text stream filter. No dependencies.
package htf_pkg;

    localparam int LIST_DEPTH_DEF = 10;
    localparam int TAG_LEN_DEF    = 62;
    localparam int NAME_BYTES     = 10;
    localparam int NAME_W         = NAME_BYTES * 8;
    localparam int RULE_MAX       = 40;
    localparam int CNT_W          = 16;
    localparam int LIST_W         = CNT_W + 1;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef logic [4:0] act_t;
    localparam act_t ACT_NONE    = 5'd0;
    localparam act_t ACT_NL1     = 5'd1;
    localparam act_t ACT_NL2     = 5'd2;
    localparam act_t ACT_NL3     = 5'd3;
    localparam act_t ACT_BR      = 5'd4;
    localparam act_t ACT_LI      = 5'd5;
    localparam act_t ACT_UL      = 5'd6;
    localparam act_t ACT_OL      = 5'd7;
    localparam act_t ACT_LEND    = 5'd8;
    localparam act_t ACT_SUP     = 5'd9;
    localparam act_t ACT_HR      = 5'd10;
    localparam act_t ACT_QUOTE   = 5'd11;
    localparam act_t ACT_PRE_ON  = 5'd12;
    localparam act_t ACT_PRE_OFF = 5'd13;
    localparam act_t ACT_SCR_ON  = 5'd14;
    localparam act_t ACT_SCR_OFF = 5'd15;
    localparam act_t ACT_STY_ON  = 5'd16;
    localparam act_t ACT_STY_OFF = 5'd17;
    localparam act_t ACT_ECHO    = 5'd18;

    // mode bits
    localparam int MODE_PRE    = 0;
    localparam int MODE_STYLE  = 1;
    localparam int MODE_SCRIPT = 2;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SP || c == CH_NL || c == CH_TAB;
    endfunction

    function automatic logic nm_is(input logic [NAME_W-1:0] nm, input logic [3:0] len,
                                   input logic [NAME_W-1:0] lit, input logic [3:0] n);
        return nm == lit && len == n;
    endfunction

    // name register holds the name right aligned, zero filled on the left
    function automatic act_t tag_action(input logic [NAME_W-1:0] nm, input logic [3:0] len,
                                        input logic closing, input logic too_long);
        act_t a;
        a = ACT_ECHO;
        if (too_long) begin
            a = ACT_ECHO;
        end else if (nm_is(nm, len, NAME_W'("p"), 4'd1) ||
                     nm_is(nm, len, NAME_W'("details"), 4'd7) ||
                     nm_is(nm, len, NAME_W'("blockquote"), 4'd10)) begin
            a = ACT_NL2;
        end else if (nm_is(nm, len, NAME_W'("div"), 4'd3) ||
                     nm_is(nm, len, NAME_W'("section"), 4'd7) ||
                     nm_is(nm, len, NAME_W'("footer"), 4'd6) ||
                     nm_is(nm, len, NAME_W'("summary"), 4'd7)) begin
            a = ACT_NL1;
        end else if (nm_is(nm, len, NAME_W'("span"), 4'd4) ||
                     nm_is(nm, len, NAME_W'("code"), 4'd4) ||
                     nm_is(nm, len, NAME_W'("a"), 4'd1) ||
                     nm_is(nm, len, NAME_W'("b"), 4'd1) ||
                     nm_is(nm, len, NAME_W'("i"), 4'd1) ||
                     nm_is(nm, len, NAME_W'("em"), 4'd2) ||
                     nm_is(nm, len, NAME_W'("mark"), 4'd4) ||
                     nm_is(nm, len, NAME_W'("small"), 4'd5) ||
                     nm_is(nm, len, NAME_W'("time"), 4'd4) ||
                     nm_is(nm, len, NAME_W'("strong"), 4'd6)) begin
            a = ACT_NONE;
        end else if (nm_is(nm, len, NAME_W'("q"), 4'd1)) begin
            a = ACT_QUOTE;
        end else if (nm_is(nm, len, NAME_W'("h1"), 4'd2) ||
                     nm_is(nm, len, NAME_W'("h2"), 4'd2) ||
                     nm_is(nm, len, NAME_W'("h3"), 4'd2) ||
                     nm_is(nm, len, NAME_W'("h4"), 4'd2) ||
                     nm_is(nm, len, NAME_W'("h5"), 4'd2) ||
                     nm_is(nm, len, NAME_W'("h6"), 4'd2)) begin
            a = closing ? ACT_NL2 : ACT_NL3;
        end else if (nm_is(nm, len, NAME_W'("li"), 4'd2)) begin
            a = closing ? ACT_NL1 : ACT_LI;
        end else if (nm_is(nm, len, NAME_W'("ul"), 4'd2)) begin
            a = closing ? ACT_LEND : ACT_UL;
        end else if (nm_is(nm, len, NAME_W'("ol"), 4'd2)) begin
            a = closing ? ACT_LEND : ACT_OL;
        end else if (nm_is(nm, len, NAME_W'("pre"), 4'd3)) begin
            a = closing ? ACT_PRE_OFF : ACT_PRE_ON;
        end else if (nm_is(nm, len, NAME_W'("script"), 4'd6)) begin
            a = closing ? ACT_SCR_OFF : ACT_SCR_ON;
        end else if (nm_is(nm, len, NAME_W'("style"), 4'd5)) begin
            a = closing ? ACT_STY_OFF : ACT_STY_ON;
        end else if (!closing && nm_is(nm, len, NAME_W'("br"), 4'd2)) begin
            a = ACT_BR;
        end else if (!closing && nm_is(nm, len, NAME_W'("sup"), 4'd3)) begin
            a = ACT_SUP;
        end else if (!closing && nm_is(nm, len, NAME_W'("hr"), 4'd2)) begin
            a = ACT_HR;
        end
        return a;
    endfunction

endpackage

FILE: rtl/htf_ram.sv
// htf_ram: single write port, single read port synchronous memory with a
// registered read. No dependencies.
module htf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/html_to_text_stream_filter_unit.sv
// html_to_text_stream_filter_unit: top level of the html to text filter.
// Depends on htf_pkg and htf_ram (tag byte buffer and list level stack).
//
// One HTML byte is taken per request and turned into zero or more text bytes.
// A plain text byte passes through accept, emit and end of run; a buffered tag
// byte is only accepted. A closing '>' runs a sequencer that produces
// one output byte per cycle: newlines, indent, bullet or digits (one decimal
// digit per cycle from the list count read out of the list stack memory),
// dash rule, or the tag echoed byte by byte from the tag buffer memory. The
// last byte of each run is held in the hold stage so it can carry last_of_run. A
// stalled result channel stalls the sequencer. No clearing pass is needed.
module html_to_text_stream_filter_unit #(
    parameter int MAX_LIST_DEPTH = htf_pkg::LIST_DEPTH_DEF,
    parameter int TAG_BUFFER_LEN = htf_pkg::TAG_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_doc_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_run,
    output logic       m_tag_cut
);
    import htf_pkg::*;

    localparam int TA = (TAG_BUFFER_LEN > 1) ? $clog2(TAG_BUFFER_LEN) : 1;
    localparam int CW = $clog2(TAG_BUFFER_LEN + 1);
    localparam int LA = (MAX_LIST_DEPTH > 1) ? $clog2(MAX_LIST_DEPTH) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ACT    = 4'd1;
    localparam logic [3:0] S_NL     = 4'd2;
    localparam logic [3:0] S_POST   = 4'd3;
    localparam logic [3:0] S_SEQ    = 4'd4;
    localparam logic [3:0] S_SPC    = 4'd5;
    localparam logic [3:0] S_LIDATA = 4'd6;
    localparam logic [3:0] S_DIGIT  = 4'd7;
    localparam logic [3:0] S_NUM    = 4'd8;
    localparam logic [3:0] S_DASH   = 4'd9;
    localparam logic [3:0] S_EOPEN  = 4'd10;
    localparam logic [3:0] S_EBYTE  = 4'd11;
    localparam logic [3:0] S_ECLOSE = 4'd12;
    localparam logic [3:0] S_FLUSH  = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [5:0]        rule_reg, rule_next;
    logic              inside_reg, inside_next;
    logic [CW-1:0]     tcount_reg, tcount_next;
    logic              ovf_reg, ovf_next;
    logic [3:0]        depth_reg, depth_next;
    logic [2:0]        mode_reg, mode_next;
    logic [7:0]        r0_reg, r0_next, r1_reg, r1_next, r2_reg, r2_next;
    logic [1:0]        seen_reg, seen_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [3:0]        nlen_reg, nlen_next;
    logic              closing_reg, closing_next;
    logic              ndone_reg, ndone_next;
    logic              nlong_reg, nlong_next;
    act_t              act_reg, act_next;
    logic [1:0]        nl_left_reg, nl_left_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [7:0]        first_ch_reg, first_ch_next;
    logic              first_reg, first_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]  v_reg, v_next;
    logic [3:0]        dig_reg [5];
    logic [3:0]        dig_next [5];
    logic [2:0]        nd_reg, nd_next;
    logic              hold_v_reg, hold_v_next;
    logic [7:0]        hold_ch_reg, hold_ch_next;
    logic              hold_cut_reg, hold_cut_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_ch_reg, m_ch_next;
    logic              m_last_reg, m_last_next;
    logic              m_cut_reg, m_cut_next;

    logic              gen_want, gen_fire, gen_cut, out_free;
    logic [7:0]        gen_ch;
    logic              tag_we;
    logic [TA-1:0]     tag_waddr, tag_raddr;
    logic [7:0]        tag_rdata;
    logic              list_we;
    logic [LA-1:0]     list_waddr, list_raddr;
    logic [LIST_W-1:0] list_wdata, list_rdata;
    logic [31:0]       prod;
    logic [CNT_W-1:0]  quot;
    logic [1:0]        nl_have, nl_want;
    logic [3:0]        depth_m1;

    htf_ram #(.WIDTH(8), .DEPTH(TAG_BUFFER_LEN), .AW(TA)) u_tag_ram (
        .aclk(aclk), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(s_in_char),
        .rd_addr(tag_raddr), .rd_data(tag_rdata)
    );

    htf_ram #(.WIDTH(LIST_W), .DEPTH(MAX_LIST_DEPTH), .AW(LA)) u_list_ram (
        .aclk(aclk), .wr_en(list_we), .wr_addr(list_waddr), .wr_data(list_wdata),
        .rd_addr(list_raddr), .rd_data(list_rdata)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_ch_reg;
    assign m_last_of_run = m_last_reg;
    assign m_tag_cut     = m_cut_reg;

    assign depth_m1   = depth_reg - 4'd1;
    assign list_raddr = depth_m1[LA-1:0];
    assign out_free   = !m_valid_reg || m_ready;
    assign gen_fire   = gen_want && (!hold_v_reg || out_free);

    // divide by ten through the reciprocal
    assign prod = 32'(v_reg) * 32'd52429;
    assign quot = CNT_W'(prod[31:19]);

    // trailing newlines already in the history
    always_comb begin
        nl_have = 2'd0;
        if (seen_reg >= 2'd1 && r0_reg == CH_NL) begin
            nl_have = 2'd1;
            if (seen_reg >= 2'd2 && r1_reg == CH_NL) begin
                nl_have = 2'd2;
                if (seen_reg == 2'd3 && r2_reg == CH_NL) begin
                    nl_have = 2'd3;
                end
            end
        end
    end

    // byte generator for the current sequencer state
    always_comb begin
        gen_want = 1'b0;
        gen_ch   = CH_SP;
        gen_cut  = 1'b0;
        case (state_reg)
            S_SEQ: begin
                gen_want = 1'b1;
                gen_ch   = first_reg ? first_ch_reg : CH_SP;
            end
            S_NL: begin
                gen_want = (nl_left_reg != 2'd0);
                gen_ch   = CH_NL;
            end
            S_SPC: begin
                gen_want = (cnt_reg != 6'd0);
            end
            S_DASH: begin
                gen_want = (cnt_reg != 6'd0);
                gen_ch   = CH_DASH;
            end
            S_NUM: begin
                gen_want = 1'b1;
                gen_ch   = {4'h3, dig_reg[nd_reg - 3'd1]};
            end
            S_EOPEN: begin
                gen_want = 1'b1;
                gen_ch   = CH_LT;
                gen_cut  = ovf_reg;
            end
            S_EBYTE: begin
                gen_want = (idx_reg != tcount_reg);
                gen_ch   = tag_rdata;
                gen_cut  = ovf_reg;
            end
            S_ECLOSE: begin
                gen_want = 1'b1;
                gen_ch   = CH_GT;
                gen_cut  = ovf_reg;
            end
            default: begin
                gen_want = 1'b0;
            end
        endcase
    end

    // echo read address runs one ahead when a byte leaves
    always_comb begin
        tag_raddr = '0;
        if (state_reg == S_EBYTE) begin
            tag_raddr = gen_fire ? TA'(idx_reg + CW'(1)) : TA'(idx_reg);
        end
    end

    // next state of everything
    always_comb begin
        state_next    = state_reg;
        rule_next     = rule_reg;
        inside_next   = inside_reg;
        tcount_next   = tcount_reg;
        ovf_next      = ovf_reg;
        depth_next    = depth_reg;
        mode_next     = mode_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        seen_next     = seen_reg;
        name_next     = name_reg;
        nlen_next     = nlen_reg;
        closing_next  = closing_reg;
        ndone_next    = ndone_reg;
        nlong_next    = nlong_reg;
        act_next      = act_reg;
        nl_left_next  = nl_left_reg;
        cnt_next      = cnt_reg;
        first_ch_next = first_ch_reg;
        first_next    = first_reg;
        idx_next      = idx_reg;
        v_next        = v_reg;
        dig_next      = dig_reg;
        nd_next       = nd_reg;
        hold_v_next   = hold_v_reg;
        hold_ch_next  = hold_ch_reg;
        hold_cut_next = hold_cut_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_ch_next     = m_ch_reg;
        m_last_next   = m_last_reg;
        m_cut_next    = m_cut_reg;
        tag_we        = 1'b0;
        tag_waddr     = TA'(tcount_reg);
        list_we       = 1'b0;
        list_waddr    = depth_reg[LA-1:0];
        list_wdata    = '0;
        nl_want       = 2'd0;

        if (cfg_we) begin
            rule_next = cfg_wdata;
        end

        // generated byte enters the hold stage, the previous one moves out
        if (gen_fire) begin
            if (hold_v_reg) begin
                m_valid_next = 1'b1;
                m_ch_next    = hold_ch_reg;
                m_last_next  = 1'b0;
                m_cut_next   = hold_cut_reg;
            end
            hold_v_next   = 1'b1;
            hold_ch_next  = gen_ch;
            hold_cut_next = gen_cut;
            r2_next       = r1_reg;
            r1_next       = r0_reg;
            r0_next       = gen_ch;
            if (seen_reg != 2'd3) begin
                seen_next = seen_reg + 2'd1;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_doc_start) begin
                        depth_next  = 4'd0;
                        mode_next   = 3'd0;
                        inside_next = 1'b0;
                        tcount_next = '0;
                        ovf_next    = 1'b0;
                        r0_next     = 8'd0;
                        r1_next     = 8'd0;
                        r2_next     = 8'd0;
                        seen_next   = 2'd0;
                    end
                    first_ch_next = s_in_char;
                    first_next    = 1'b1;
                    cnt_next      = 6'd1;
                    if (!inside_reg || s_doc_start) begin
                        // text byte
                        if (s_in_char == CH_LT) begin
                            inside_next  = 1'b1;
                            tcount_next  = '0;
                            ovf_next     = 1'b0;
                            name_next    = '0;
                            nlen_next    = 4'd0;
                            closing_next = 1'b0;
                            ndone_next   = 1'b0;
                            nlong_next   = 1'b0;
                        end else if (!s_doc_start &&
                                     (mode_reg[MODE_STYLE] || mode_reg[MODE_SCRIPT])) begin
                            state_next = S_IDLE;
                        end else if ((s_doc_start || !mode_reg[MODE_PRE]) &&
                                     is_ws(s_in_char)) begin
                            if (!s_doc_start && seen_reg != 2'd0 && !is_ws(r0_reg)) begin
                                first_ch_next = CH_SP;
                                state_next    = S_SEQ;
                            end
                        end else begin
                            state_next = S_SEQ;
                        end
                    end else if (s_in_char == CH_GT) begin
                        inside_next = 1'b0;
                        act_next    = tag_action(name_reg, nlen_reg, closing_reg, nlong_reg);
                        state_next  = S_ACT;
                    end else if (tcount_reg < CW'(TAG_BUFFER_LEN)) begin
                        // buffer the byte and track the name
                        tag_we      = 1'b1;
                        tcount_next = tcount_reg + CW'(1);
                        if (tcount_reg == '0 && s_in_char == CH_SLASH) begin
                            closing_next = 1'b1;
                        end else if (!ndone_reg) begin
                            if (is_ws(s_in_char)) begin
                                ndone_next = 1'b1;
                            end else if (nlen_reg < 4'(NAME_BYTES)) begin
                                name_next = {name_reg[NAME_W-9:0], s_in_char};
                                nlen_next = nlen_reg + 4'd1;
                            end else begin
                                nlong_next = 1'b1;
                            end
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end

            // first step of a matched tag
            S_ACT: begin
                first_next = 1'b1;
                cnt_next   = 6'd1;
                state_next = S_NL;
                case (act_reg)
                    ACT_NL1, ACT_LI, ACT_HR: nl_want = 2'd1;
                    ACT_NL2, ACT_LEND:       nl_want = 2'd2;
                    ACT_NL3:                 nl_want = 2'd3;
                    ACT_UL, ACT_OL: begin
                        if (depth_reg >= 4'(MAX_LIST_DEPTH)) begin
                            state_next = S_FLUSH;
                        end else begin
                            nl_want = 2'd2;
                        end
                    end
                    ACT_PRE_ON: begin
                        mode_next[MODE_PRE] = 1'b1;
                        nl_want = 2'd2;
                    end
                    ACT_PRE_OFF: begin
                        mode_next[MODE_PRE] = 1'b0;
                        nl_want = 2'd2;
                    end
                    ACT_BR: begin
                        first_ch_next = CH_NL;
                        state_next    = S_SEQ;
                    end
                    ACT_SUP: begin
                        first_ch_next = CH_CARET;
                        state_next    = S_SEQ;
                    end
                    ACT_QUOTE: begin
                        first_ch_next = CH_QUOTE;
                        state_next    = S_SEQ;
                    end
                    ACT_SCR_ON: begin
                        mode_next[MODE_SCRIPT] = 1'b1;
                        state_next = S_FLUSH;
                    end
                    ACT_SCR_OFF: begin
                        mode_next[MODE_SCRIPT] = 1'b0;
                        state_next = S_FLUSH;
                    end
                    ACT_STY_ON: begin
                        mode_next[MODE_STYLE] = 1'b1;
                        state_next = S_FLUSH;
                    end
                    ACT_STY_OFF: begin
                        mode_next[MODE_STYLE] = 1'b0;
                        state_next = S_FLUSH;
                    end
                    ACT_ECHO: state_next = S_EOPEN;
                    default:  state_next = S_FLUSH;
                endcase
                nl_left_next = (nl_want > nl_have) ? nl_want - nl_have : 2'd0;
            end

            S_NL: begin
                if (nl_left_reg == 2'd0) begin
                    state_next = S_POST;
                end else if (gen_fire) begin
                    nl_left_next = nl_left_reg - 2'd1;
                end
            end

            // work after the newlines
            S_POST: begin
                first_next = 1'b1;
                state_next = S_FLUSH;
                case (act_reg)
                    ACT_LI: begin
                        if (depth_reg == 4'd0) begin
                            first_ch_next = CH_STAR;
                            cnt_next      = 6'd3;
                            state_next    = S_SEQ;
                        end else begin
                            cnt_next   = 6'(depth_reg) * 6'd3;
                            state_next = S_SPC;
                        end
                    end
                    ACT_UL, ACT_OL: begin
                        list_we    = 1'b1;
                        list_wdata = {(act_reg == ACT_OL), {CNT_W{1'b0}}};
                        depth_next = depth_reg + 4'd1;
                    end
                    ACT_LEND: begin
                        if (depth_reg != 4'd0) begin
                            depth_next = depth_reg - 4'd1;
                        end
                    end
                    ACT_HR: begin
                        cnt_next   = (rule_reg > 6'(RULE_MAX)) ? 6'(RULE_MAX) : rule_reg;
                        state_next = S_DASH;
                    end
                    default: state_next = S_FLUSH;
                endcase
            end

            S_SPC: begin
                if (cnt_reg == 6'd0) begin
                    state_next = S_LIDATA;
                end else if (gen_fire) begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end

            // list entry read during the indent; for an ordered list bump the count and write back
            S_LIDATA: begin
                first_next = 1'b1;
                if (!list_rdata[CNT_W]) begin
                    first_ch_next = CH_STAR;
                    cnt_next      = 6'd3;
                    state_next    = S_SEQ;
                end else begin
                    list_we    = 1'b1;
                    list_waddr = depth_m1[LA-1:0];
                    if (list_rdata[CNT_W-1:0] != {CNT_W{1'b1}}) begin
                        v_next = list_rdata[CNT_W-1:0] + CNT_W'(1);
                    end else begin
                        v_next = list_rdata[CNT_W-1:0];
                    end
                    list_wdata = {1'b1, v_next};
                    nd_next    = 3'd0;
                    state_next = S_DIGIT;
                end
            end

            // one decimal digit per cycle, least significant first
            S_DIGIT: begin
                dig_next[nd_reg] = 4'(v_reg - quot * CNT_W'(10));
                nd_next = nd_reg + 3'd1;
                v_next  = quot;
                if (quot == '0 || nd_reg == 3'd4) begin
                    state_next = S_NUM;
                end
            end

            S_NUM: begin
                if (gen_fire) begin
                    nd_next = nd_reg - 3'd1;
                    if (nd_reg == 3'd1) begin
                        first_ch_next = CH_DOT;
                        first_next    = 1'b1;
                        cnt_next      = 6'd2;
                        state_next    = S_SEQ;
                    end
                end
            end

            S_DASH: begin
                if (cnt_reg == 6'd0) begin
                    first_ch_next = CH_NL;
                    first_next    = 1'b1;
                    cnt_next      = 6'd1;
                    state_next    = S_SEQ;
                end else if (gen_fire) begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end

            // short fixed run: first byte then spaces
            S_SEQ: begin
                if (gen_fire) begin
                    first_next = 1'b0;
                    cnt_next   = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_EOPEN: begin
                idx_next = '0;
                if (gen_fire) begin
                    state_next = S_EBYTE;
                end
            end

            S_EBYTE: begin
                if (idx_reg == tcount_reg) begin
                    state_next = S_ECLOSE;
                end else if (gen_fire) begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_ECLOSE: begin
                if (gen_fire) begin
                    state_next = S_FLUSH;
                end
            end

            // release the held byte marked as last of the run
            S_FLUSH: begin
                if (!hold_v_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ch_next    = hold_ch_reg;
                    m_last_next  = 1'b1;
                    m_cut_next   = hold_cut_reg;
                    hold_v_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rule_reg    <= 6'(RULE_MAX);
            inside_reg  <= 1'b0;
            tcount_reg  <= '0;
            ovf_reg     <= 1'b0;
            depth_reg   <= 4'd0;
            mode_reg    <= 3'd0;
            r0_reg      <= 8'd0;
            r1_reg      <= 8'd0;
            r2_reg      <= 8'd0;
            seen_reg    <= 2'd0;
            hold_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rule_reg    <= rule_next;
            inside_reg  <= inside_next;
            tcount_reg  <= tcount_next;
            ovf_reg     <= ovf_next;
            depth_reg   <= depth_next;
            mode_reg    <= mode_next;
            r0_reg      <= r0_next;
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            seen_reg    <= seen_next;
            hold_v_reg  <= hold_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        name_reg     <= name_next;
        nlen_reg     <= nlen_next;
        closing_reg  <= closing_next;
        ndone_reg    <= ndone_next;
        nlong_reg    <= nlong_next;
        act_reg      <= act_next;
        nl_left_reg  <= nl_left_next;
        cnt_reg      <= cnt_next;
        first_ch_reg <= first_ch_next;
        first_reg    <= first_next;
        idx_reg      <= idx_next;
        v_reg        <= v_next;
        dig_reg      <= dig_next;
        nd_reg       <= nd_next;
        hold_ch_reg  <= hold_ch_next;
        hold_cut_reg <= hold_cut_next;
        m_ch_reg     <= m_ch_next;
        m_last_reg   <= m_last_next;
        m_cut_reg    <= m_cut_next;
    end

    // a new request only starts with an empty hold stage
    a_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_v_reg) else $error("hold stage busy while idle");

    // the hold stage never overwrites a byte the output cannot take
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_fire && hold_v_reg) |-> out_free) else $error("held byte lost");

    // list nesting stays within the stack
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= 4'(MAX_LIST_DEPTH)) else $error("list depth overflow");

    // tag fill count stays within the buffer
    a_tag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tcount_reg <= CW'(TAG_BUFFER_LEN)) else $error("tag count overflow");

endmodule

FILE: dv/html_to_text_stream_filter_unit_tb.sv
// html_to_text_stream_filter_unit_tb: self-checking bench for the html to text filter.
// Drives byte requests, predicts the text stream in a local model, checks every result byte.
// Depends on htf_pkg and html_to_text_stream_filter_unit.
module html_to_text_stream_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import htf_pkg::*;

    localparam int DEPTH_MAX   = LIST_DEPTH_DEF;
    localparam int TBUF_LEN    = TAG_LEN_DEF;
    localparam int PHASE_ITEMS = 50;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       cut;
    } text_byte_t;

    typedef struct {
        logic [7:0] ch;
        logic       ds;
        logic       has_exp;
        logic [7:0] exp_ch;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [5:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char = '0;
    logic       s_doc_start = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last_of_run;
    logic       m_tag_cut;

    html_to_text_stream_filter_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_char    (s_in_char),
        .s_doc_start  (s_doc_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last_of_run(m_last_of_run),
        .m_tag_cut    (m_tag_cut)
    );

    always #1 aclk = ~aclk;

    // shared bench state
    text_byte_t expected_text[$];
    text_byte_t run_bytes[$];
    int         fail_count = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         hold_left = 0;
    logic       hold_req = 1'b0;
    logic       hold_done = 1'b0;
    int         quiet_cycles = 0;

    // filter model state
    logic [5:0] rule_w;
    logic       in_tag;
    logic [7:0] tbuf [TBUF_LEN];
    int         tcnt;
    logic       tovf;
    int         depth;
    logic       lvl_ordered [DEPTH_MAX];
    int         lvl_count [DEPTH_MAX];
    logic       pre_on, style_on, script_on;
    logic [7:0] hist [3];
    int         seen;

    function automatic logic ws(input logic [7:0] c);
        return c == CH_SP || c == CH_NL || c == CH_TAB;
    endfunction

    task automatic put(input logic [7:0] c, input logic cut);
        run_bytes.push_back('{ch: c, last: 1'b0, cut: cut});
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = c;
        if (seen < 3) seen++;
    endtask

    task automatic newlines(input int n);
        int k;
        k = 0;
        while (k < n && k < seen && hist[k] == CH_NL) k++;
        for (; k < n; k++) put(CH_NL, 1'b0);
    endtask

    task automatic star;
        put(CH_STAR, 1'b0);
        put(CH_SP, 1'b0);
        put(CH_SP, 1'b0);
    endtask

    task automatic bullet;
        string num;
        newlines(1);
        if (depth == 0) begin
            star();
            return;
        end
        for (int i = 0; i < 3 * depth; i++) put(CH_SP, 1'b0);
        if (!lvl_ordered[depth-1]) begin
            star();
        end else begin
            if (lvl_count[depth-1] < 65535) lvl_count[depth-1]++;
            num = $sformatf("%0d", lvl_count[depth-1]);
            for (int i = 0; i < num.len(); i++) put(num[i], 1'b0);
            put(CH_DOT, 1'b0);
            put(CH_SP, 1'b0);
        end
    endtask

    task automatic open_list(input logic ordered);
        if (depth >= DEPTH_MAX) return;
        newlines(2);
        depth++;
        lvl_ordered[depth-1] = ordered;
        if (ordered) lvl_count[depth-1] = 0;
    endtask

    // tag name to action, unmatched names echo
    function automatic act_t name_action(input string nm, input logic closing);
        case (nm)
            "span", "code", "a", "b", "i", "em", "mark", "small", "time", "strong":
                return ACT_NONE;
            "p", "details", "blockquote": return ACT_NL2;
            "div", "section", "footer", "summary": return ACT_NL1;
            "q": return ACT_QUOTE;
            "h1", "h2", "h3", "h4", "h5", "h6": return closing ? ACT_NL2 : ACT_NL3;
            "li": return closing ? ACT_NL1 : ACT_LI;
            "ul": return closing ? ACT_LEND : ACT_UL;
            "ol": return closing ? ACT_LEND : ACT_OL;
            "pre": return closing ? ACT_PRE_OFF : ACT_PRE_ON;
            "script": return closing ? ACT_SCR_OFF : ACT_SCR_ON;
            "style": return closing ? ACT_STY_OFF : ACT_STY_ON;
            "br": return closing ? ACT_ECHO : ACT_BR;
            "sup": return closing ? ACT_ECHO : ACT_SUP;
            "hr": return closing ? ACT_ECHO : ACT_HR;
            default: return ACT_ECHO;
        endcase
    endfunction

    // closing '>' of a tag
    task automatic close_tag;
        int    first, stop, rw;
        logic  closing, has_nul;
        string nm;
        act_t  a;
        first = 0;
        closing = 1'b0;
        has_nul = 1'b0;
        nm = "";
        if (tcnt > 0 && tbuf[0] == CH_SLASH) begin
            closing = 1'b1;
            first = 1;
        end
        stop = first;
        while (stop < tcnt && !ws(tbuf[stop])) stop++;
        for (int i = first; i < stop; i++) begin
            if (tbuf[i] == 8'h00) has_nul = 1'b1;
            else nm = {nm, string'(tbuf[i])};
        end
        a = has_nul ? ACT_ECHO : name_action(nm, closing);
        case (a)
            ACT_NL1: newlines(1);
            ACT_NL2: newlines(2);
            ACT_NL3: newlines(3);
            ACT_BR: put(CH_NL, 1'b0);
            ACT_LI: bullet();
            ACT_UL: open_list(1'b0);
            ACT_OL: open_list(1'b1);
            ACT_LEND: begin
                newlines(2);
                if (depth > 0) depth--;
            end
            ACT_SUP: put(CH_CARET, 1'b0);
            ACT_HR: begin
                newlines(1);
                rw = rule_w > RULE_MAX ? RULE_MAX : rule_w;
                for (int i = 0; i < rw; i++) put(CH_DASH, 1'b0);
                put(CH_NL, 1'b0);
            end
            ACT_QUOTE: put(CH_QUOTE, 1'b0);
            ACT_PRE_ON: begin
                pre_on = 1'b1;
                newlines(2);
            end
            ACT_PRE_OFF: begin
                pre_on = 1'b0;
                newlines(2);
            end
            ACT_SCR_ON: script_on = 1'b1;
            ACT_SCR_OFF: script_on = 1'b0;
            ACT_STY_ON: style_on = 1'b1;
            ACT_STY_OFF: style_on = 1'b0;
            ACT_ECHO: begin
                put(CH_LT, tovf);
                for (int i = 0; i < tcnt; i++) put(tbuf[i], tovf);
                put(CH_GT, tovf);
            end
            default: ;
        endcase
    endtask

    // text bytes caused by one request, left in run_bytes
    task automatic filter_byte(input logic [7:0] c, input logic ds);
        run_bytes.delete();
        if (ds) begin
            depth = 0;
            pre_on = 1'b0;
            style_on = 1'b0;
            script_on = 1'b0;
            in_tag = 1'b0;
            tcnt = 0;
            tovf = 1'b0;
            hist = '{default: 8'h00};
            seen = 0;
        end
        if (!in_tag) begin
            if (c == CH_LT) begin
                in_tag = 1'b1;
                tcnt = 0;
                tovf = 1'b0;
            end else if (style_on || script_on) begin
                // dropped
            end else if (!pre_on && ws(c)) begin
                if (seen > 0 && !ws(hist[0])) put(CH_SP, 1'b0);
            end else begin
                put(c, 1'b0);
            end
        end else if (c == CH_GT) begin
            in_tag = 1'b0;
            close_tag();
        end else if (tcnt < TBUF_LEN) begin
            tbuf[tcnt] = c;
            tcnt++;
        end else begin
            tovf = 1'b1;
        end
        if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].last = 1'b1;
    endtask

    // one request on the input channel
    task automatic send_byte(input logic [7:0] c, input logic ds, input logic typed,
                             input logic [7:0] typed_ch);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_char <= c;
        s_doc_start <= ds;
        do @(posedge aclk); while (!s_ready);
        filter_byte(c, ds);
        if (typed) expected_text.push_back('{ch: typed_ch, last: 1'b1, cut: 1'b0});
        else foreach (run_bytes[i]) expected_text.push_back(run_bytes[i]);
    endtask

    task automatic send_text(input string s, input logic ds);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], ds && i == 0, 1'b0, 8'h00);
    endtask

    // wait for the stream to empty, then write the rule width
    task automatic set_rule(input logic [5:0] w);
        s_valid <= 1'b0;
        while (expected_text.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        rule_w = w;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    string tag_names [] = '{"span", "p", "details", "br", "li", "ul", "ol", "h1", "h6", "div",
        "section", "footer", "summary", "sup", "hr", "blockquote", "q", "code", "a", "b", "i",
        "em", "mark", "small", "time", "strong", "pre", "script", "style", "H1", "spa", "hrx"};

    function automatic string word(input int n);
        string w;
        w = "";
        for (int i = 0; i < n; i++) w = {w, string'(8'($urandom_range(97, 122)))};
        return w;
    endfunction

    function automatic logic [7:0] tag_noise();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_GT);
        return b;
    endfunction

    // random document fragments, mostly well formed
    task automatic random_phase(input int n_items);
        int    sent;
        logic  ds;
        string t;
        int    kind, n;
        sent = 0;
        while (sent < n_items) begin
            ds = $urandom_range(99) < 5;
            kind = $urandom_range(9);
            t = "";
            case (kind)
                0: t = {word($urandom_range(1, 6)), " "};
                1, 2, 3, 4: begin
                    t = "<";
                    if ($urandom_range(2) == 0) t = {t, "/"};
                    t = {t, tag_names[$urandom_range(tag_names.size() - 1)]};
                    if ($urandom_range(3) == 0) t = {t, " x=1"};
                    t = {t, ">"};
                end
                5: begin
                    if ($urandom_range(1)) t = "<ol>";
                    else t = "<ul>";
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) t = {t, "<li>", word(2)};
                    if ($urandom_range(3) != 0) t = {t, "</ol>"};
                end
                6, 7: begin
                    n = (kind == 7 && $urandom_range(2) == 0) ? $urandom_range(60, 70)
                                                              : $urandom_range(0, 5);
                    send_byte(CH_LT, ds, 1'b0, 8'h00);
                    for (int i = 0; i < n; i++) send_byte(tag_noise(), 1'b0, 1'b0, 8'h00);
                    send_byte(CH_GT, 1'b0, 1'b0, 8'h00);
                    sent += n + 2;
                end
                8: begin
                    send_byte(8'($urandom_range(255)), ds, 1'b0, 8'h00);
                    sent++;
                end
                default: begin
                    if ($urandom_range(1)) t = "\t\n  ";
                    else t = " \n";
                end
            endcase
            if (t.len() > 0) begin
                send_text(t, ds);
                sent += t.len();
            end
        end
    endtask

    // directed requests: extremes, a rule, a list item, an empty tag
    dir_row_t directed [] = '{
        '{8'h41, 1'b1, 1'b1, 8'h41}, '{8'hff, 1'b0, 1'b1, 8'hff},
        '{8'h00, 1'b0, 1'b1, 8'h00}, '{8'h20, 1'b0, 1'b0, 8'h00},
        '{8'h3c, 1'b0, 1'b0, 8'h00}, '{8'h68, 1'b0, 1'b0, 8'h00},
        '{8'h72, 1'b0, 1'b0, 8'h00}, '{8'h3e, 1'b0, 1'b0, 8'h00},
        '{8'h3c, 1'b0, 1'b0, 8'h00}, '{8'h6f, 1'b0, 1'b0, 8'h00},
        '{8'h6c, 1'b0, 1'b0, 8'h00}, '{8'h3e, 1'b0, 1'b0, 8'h00},
        '{8'h3c, 1'b0, 1'b0, 8'h00}, '{8'h6c, 1'b0, 1'b0, 8'h00},
        '{8'h69, 1'b0, 1'b0, 8'h00}, '{8'h3e, 1'b0, 1'b0, 8'h00},
        '{8'h3c, 1'b0, 1'b0, 8'h00}, '{8'h3e, 1'b0, 1'b0, 8'h00},
        '{8'h3c, 1'b0, 1'b0, 8'h00}, '{8'h2f, 1'b0, 1'b0, 8'h00},
        '{8'h75, 1'b0, 1'b0, 8'h00}, '{8'h6c, 1'b0, 1'b0, 8'h00},
        '{8'h3e, 1'b0, 1'b0, 8'h00}
    };

    // result channel readiness, with one long hold-off counted here
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    // compare each result with the oldest expected byte
    always @(posedge aclk) begin
        text_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected byte 8'h%02h last %0b cut %0b", $realtime,
                         m_out_char, m_last_of_run, m_tag_cut);
                fail_count++;
            end else begin
                want = expected_text.pop_front();
                if (want.ch !== m_out_char) begin
                    $display("%0t: out_char expected 8'h%02h actual 8'h%02h", $realtime,
                             want.ch, m_out_char);
                    fail_count++;
                end
                if (want.last !== m_last_of_run) begin
                    $display("%0t: last_of_run expected %0b actual %0b", $realtime,
                             want.last, m_last_of_run);
                    fail_count++;
                end
                if (want.cut !== m_tag_cut) begin
                    $display("%0t: tag_cut expected %0b actual %0b", $realtime,
                             want.cut, m_tag_cut);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** html_to_text_stream_filter_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        rule_w = 6'(RULE_MAX);
        in_tag = 1'b0;
        tcnt = 0;
        tovf = 1'b0;
        depth = 0;
        pre_on = 1'b0;
        style_on = 1'b0;
        script_on = 1'b0;
        hist = '{default: 8'h00};
        seen = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset width
        foreach (directed[i])
            send_byte(directed[i].ch, directed[i].ds, directed[i].has_exp, directed[i].exp_ch);

        // phases: narrowest rule, over-wide rule, random, then default with a hold-off
        send_idle = 25;
        recv_idle = 64;
        set_rule(6'd0);
        send_text("<hr>", 1'b0);
        random_phase(PHASE_ITEMS);
        send_idle = 64;
        recv_idle = 25;
        set_rule(6'd63);
        send_text("<hr>", 1'b0);
        random_phase(PHASE_ITEMS);
        send_idle = 0;
        recv_idle = 0;
        set_rule(6'($urandom_range(1, 39)));
        random_phase(PHASE_ITEMS);
        set_rule(6'(RULE_MAX));
        hold_req = 1'b1;
        send_text("<hr><p>hold<br>", 1'b0);
        random_phase(PHASE_ITEMS);

        s_valid <= 1'b0;
        while (expected_text.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** html_to_text_stream_filter_unit: PASSED **");
        end else begin
            $display("** html_to_text_stream_filter_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/htf_pkg.sv
rtl/htf_ram.sv
rtl/html_to_text_stream_filter_unit.sv
dv/html_to_text_stream_filter_unit_tb.sv
